/* rtl/pid_position_controller_defines.svh */
// Assertion helpers for the controller RTL.
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define PIDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidc assertion failed");

// next-cycle implication
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidc assertion failed");

`endif

/* rtl/pidc_pkg.sv */
package pidc_pkg;

    localparam int MUL_W = 33;
    localparam int PROD_W = 64;
    localparam int DIV_W = 60;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DVSR_W = 31;

    localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] CFG_DRIVE_MIN     = 3'd3;
    localparam logic [2:0] CFG_DRIVE_MAX     = 3'd4;
    localparam logic [2:0] CFG_DEAD_ZONE     = 3'd5;
    localparam logic [2:0] CFG_SMOOTH_ALPHA  = 3'd6;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd7;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_NEW_TGT = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;
    localparam logic [1:0] MODE_UNWRAP = 2'd3;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVSR_W-1:0]  divisor;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

endpackage

/* rtl/pidc_mul.sv */
module pidc_mul (
    input  logic                                i_clk,
    input  logic signed [pidc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [pidc_pkg::MUL_W-1:0]   i_b,
    output logic signed [pidc_pkg::PROD_W-1:0]  o_prod
);
    logic signed [2*pidc_pkg::MUL_W-1:0] w_full;
    logic signed [pidc_pkg::PROD_W-1:0]  r_prod;

    assign w_full = i_a * i_b;

    // operands never exceed 31 magnitude bits each, so the low word holds the product
    always_ff @(posedge i_clk) begin
        r_prod <= w_full[pidc_pkg::PROD_W-1:0];
    end

    assign o_prod = r_prod;
endmodule

/* rtl/pidc_div.sv */
module pidc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pidc_pkg::t_div_req               i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [pidc_pkg::DIV_W-1:0]       o_quot
);
    logic                                r_busy;
    logic                                r_done;
    logic [pidc_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [pidc_pkg::DVSR_W-1:0]         r_rem;
    logic [pidc_pkg::DVSR_W-1:0]         r_dvsr;
    logic [pidc_pkg::DIV_W-1:0]          r_quot;
    logic [pidc_pkg::DVSR_W:0]           w_sh;
    logic                                w_ge;
    logic [pidc_pkg::DVSR_W:0]           w_diff;

    assign w_sh   = {r_rem, r_quot[pidc_pkg::DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvsr};
    assign w_diff = w_sh - {1'b0, r_dvsr};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
            r_quot <= i_req.dividend;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[pidc_pkg::DVSR_W-1:0] : w_sh[pidc_pkg::DVSR_W-1:0];
            r_quot <= {r_quot[pidc_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* rtl/pid_position_controller.sv */
// channel | valid      | ready        | payload
// in      | i_in_valid | o_in_ready   | i_mode, i_target_pos, i_measured_pos, i_raw_angle
// out     | o_out_valid| i_out_ready  | o_result_value, o_drive_saturated, o_integ_clamped
// cfg     | i_cfg_valid| o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Modes 1..3 go from dispatch straight to the finish state. An update may run
// up to three divisions (derivative, integral clamp, back-calculation) on the
// bit-serial divider. One item is in flight at a time.
// Reset is synchronous, active low. A waiting result is held in the output
// register; the next item may be accepted while it waits.
`include "pid_position_controller_defines.svh"

module pid_position_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic signed [31:0]  i_target_pos,
    input  logic signed [31:0]  i_measured_pos,
    input  logic [24:0]         i_raw_angle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_result_value,
    output logic                o_drive_saturated,
    output logic                o_integ_clamped,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_MP   = 5'd2;
    localparam logic [4:0] S_P    = 5'd3;
    localparam logic [4:0] S_DDIV = 5'd4;
    localparam logic [4:0] S_MA   = 5'd5;
    localparam logic [4:0] S_MB   = 5'd6;
    localparam logic [4:0] S_DS   = 5'd7;
    localparam logic [4:0] S_MD   = 5'd8;
    localparam logic [4:0] S_D    = 5'd9;
    localparam logic [4:0] S_MI   = 5'd10;
    localparam logic [4:0] S_IA   = 5'd11;
    localparam logic [4:0] S_MH   = 5'd12;
    localparam logic [4:0] S_ML   = 5'd13;
    localparam logic [4:0] S_I    = 5'd14;
    localparam logic [4:0] S_LDIV = 5'd15;
    localparam logic [4:0] S_OC   = 5'd16;
    localparam logic [4:0] S_BDIV = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;

    localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
    localparam logic signed [25:0] FULL_TURN = 26'sd23592960;
    localparam logic [16:0] Q_ONE = 17'd65536;

    // configuration
    logic [30:0]         r_prop_gain, r_integ_gain, r_deriv_gain, r_dead_zone, r_sample_period;
    logic signed [31:0]  r_drive_min, r_drive_max;
    logic [16:0]         r_smooth_alpha;

    // controller state
    logic signed [55:0]  r_integ;
    logic signed [31:0]  r_ds, r_last_meas, r_turn;
    logic [24:0]         r_last_raw;
    logic                r_dprimed, r_uprimed;

    // item work registers
    logic [4:0]          r_state;
    logic [1:0]          r_mode;
    logic signed [31:0]  r_tgt, r_meas, r_err, r_p, r_deriv, r_d, r_i, r_res;
    logic [24:0]         r_raw;
    logic signed [63:0]  r_acc;
    logic                r_neg, r_dsat, r_iclamp;

    // output register
    logic                r_ov, r_osat, r_oclamp;
    logic signed [31:0]  r_ores;

    logic signed [pidc_pkg::MUL_W-1:0]  w_ma, w_mb;
    logic signed [pidc_pkg::PROD_W-1:0] w_prod;
    pidc_pkg::t_div_req                 w_dreq;
    logic                               w_dbusy, w_ddone;
    logic [pidc_pkg::DIV_W-1:0]         w_quot;

    logic                w_in_acc;
    logic [16:0]         w_alpha;
    logic signed [32:0]  w_err33, w_err_abs, w_diff33;
    logic                w_in_dead;
    logic signed [31:0]  w_err, w_lim, w_i;
    logic signed [63:0]  w_qs, w_integ_sum, w_bc;
    logic signed [33:0]  w_out;
    logic signed [34:0]  w_exc_hi, w_exc_lo, w_exc;
    logic signed [25:0]  w_delta;
    logic signed [32:0]  w_turn_sum;
    logic                w_clamp_hi, w_clamp_lo, w_sat_hi, w_sat_lo;

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_busy  (w_dbusy),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_alpha   = (r_smooth_alpha > Q_ONE) ? Q_ONE : r_smooth_alpha;
        w_err33   = 33'(r_tgt) - 33'(r_meas);
        w_err_abs = (w_err33 < 0) ? -w_err33 : w_err33;
        w_in_dead = w_err_abs < $signed({2'b00, r_dead_zone});
        w_err     = w_in_dead ? 32'sd0 : pidc_pkg::sat32(64'(w_err33));
        w_diff33  = 33'(r_last_meas) - 33'(r_meas);

        w_integ_sum = 64'(r_integ) + (w_prod >>> 8);
        w_i = pidc_pkg::sat32(r_acc + (w_prod >>> 24));
        // drive_max / 2 truncated toward zero
        w_lim = (r_drive_max + $signed({31'd0, r_drive_max[31]})) >>> 1;
        w_clamp_hi = w_i > w_lim;
        w_clamp_lo = w_i < -w_lim;

        w_out    = 34'(r_p) + 34'(r_i) + 34'(r_d);
        w_exc_hi = 35'(w_out) - 35'(r_drive_max);
        w_exc_lo = 35'(w_out) - 35'(r_drive_min);
        w_sat_hi = w_out > 34'(r_drive_max);
        w_sat_lo = w_out < 34'(r_drive_min);
        w_exc    = w_sat_hi ? w_exc_hi : w_exc_lo;

        w_qs = r_neg ? -$signed(64'(w_quot)) : $signed(64'(w_quot));
        w_bc = 64'(r_integ) - w_qs;

        w_delta = $signed({1'b0, r_raw}) - $signed({1'b0, r_last_raw});
        if (w_delta > HALF_TURN) begin
            w_delta = w_delta - FULL_TURN;
        end else if (w_delta < -HALF_TURN) begin
            w_delta = w_delta + FULL_TURN;
        end
        w_turn_sum = 33'(r_turn) + 33'(w_delta);
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MP: begin
                w_ma = $signed({2'b00, r_prop_gain});
                w_mb = 33'(r_err);
            end
            S_MA: begin
                w_ma = $signed({16'd0, w_alpha});
                w_mb = 33'(r_deriv);
            end
            S_MB: begin
                w_ma = $signed({16'd0, Q_ONE - w_alpha});
                w_mb = 33'(r_ds);
            end
            S_MD: begin
                w_ma = $signed({2'b00, r_deriv_gain});
                w_mb = 33'(r_ds);
            end
            S_MI: begin
                w_ma = 33'(r_err);
                w_mb = $signed({2'b00, r_sample_period});
            end
            S_MH: begin
                w_ma = $signed({2'b00, r_integ_gain});
                w_mb = $signed({{9{r_integ[47]}}, r_integ[47:24]});
            end
            S_ML: begin
                w_ma = $signed({2'b00, r_integ_gain});
                w_mb = $signed({9'd0, r_integ[23:0]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider request
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = '0;
        w_dreq.divisor  = r_integ_gain;
        case (r_state)
            S_P: begin
                w_dreq.start    = r_dprimed;
                w_dreq.divisor  = r_sample_period;
                w_dreq.dividend = pidc_pkg::DIV_W'({(w_diff33 < 0) ? -w_diff33 : w_diff33,
                                                     16'd0});
            end
            S_I: begin
                w_dreq.start    = (w_clamp_hi || w_clamp_lo) && (r_integ_gain != '0);
                w_dreq.dividend = pidc_pkg::DIV_W'({(w_lim < 0) ? -w_lim : w_lim, 24'd0});
            end
            S_OC: begin
                w_dreq.start    = (w_sat_hi || w_sat_lo) && (r_integ_gain != '0);
                w_dreq.dividend = pidc_pkg::DIV_W'({(w_exc < 0) ? -w_exc : w_exc, 24'd0});
            end
            default: begin
                w_dreq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= '0;
            r_integ_gain    <= '0;
            r_deriv_gain    <= '0;
            r_drive_min     <= -32'sd6553600;
            r_drive_max     <= 32'sd6553600;
            r_dead_zone     <= 31'd3277;
            r_smooth_alpha  <= 17'd13107;
            r_sample_period <= 31'd66;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pidc_pkg::CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[30:0];
                pidc_pkg::CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data[30:0];
                pidc_pkg::CFG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_data[30:0];
                pidc_pkg::CFG_DRIVE_MIN:     r_drive_min     <= i_cfg_data;
                pidc_pkg::CFG_DRIVE_MAX:     r_drive_max     <= i_cfg_data;
                pidc_pkg::CFG_DEAD_ZONE:     r_dead_zone     <= i_cfg_data[30:0];
                pidc_pkg::CFG_SMOOTH_ALPHA:  r_smooth_alpha  <= i_cfg_data[16:0];
                pidc_pkg::CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[30:0];
                default: r_prop_gain <= r_prop_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= i_mode;
            r_tgt  <= i_target_pos;
            r_meas <= i_measured_pos;
            r_raw  <= i_raw_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_ds        <= '0;
            r_last_meas <= '0;
            r_last_raw  <= '0;
            r_turn      <= '0;
            r_dprimed   <= 1'b0;
            r_uprimed   <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_dsat   <= 1'b0;
                    r_iclamp <= 1'b0;
                    case (r_mode)
                        pidc_pkg::MODE_UPDATE: begin
                            r_res <= '0;
                            if (r_sample_period != '0) begin
                                r_err   <= w_err;
                                r_state <= S_MP;
                                if (w_in_dead) begin
                                    r_integ <= '0;
                                end
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        pidc_pkg::MODE_NEW_TGT: begin
                            r_res     <= '0;
                            r_state   <= S_FIN;
                            r_integ   <= '0;
                            r_ds      <= '0;
                            r_dprimed <= 1'b0;
                        end
                        pidc_pkg::MODE_RESET: begin
                            r_res       <= '0;
                            r_state     <= S_FIN;
                            r_integ     <= '0;
                            r_ds        <= '0;
                            r_dprimed   <= 1'b0;
                            r_last_meas <= '0;
                            r_last_raw  <= '0;
                            r_turn      <= '0;
                            r_uprimed   <= 1'b0;
                        end
                        default: begin
                            r_state    <= S_FIN;
                            r_last_raw <= r_raw;
                            r_uprimed  <= 1'b1;
                            if (!r_uprimed) begin
                                r_turn <= $signed({7'd0, r_raw});
                                r_res  <= $signed({7'd0, r_raw});
                            end else begin
                                r_turn <= pidc_pkg::sat32(64'(w_turn_sum));
                                r_res  <= pidc_pkg::sat32(64'(w_turn_sum));
                            end
                        end
                    endcase
                end
                S_MP: r_state <= S_P;
                S_P: begin
                    r_p         <= pidc_pkg::sat32(w_prod >>> 16);
                    r_neg       <= w_diff33 < 0;
                    r_last_meas <= r_meas;
                    r_dprimed   <= 1'b1;
                    r_deriv     <= '0;
                    r_state     <= r_dprimed ? S_DDIV : S_MA;
                end
                S_DDIV: begin
                    if (w_ddone) begin
                        r_deriv <= pidc_pkg::sat32(w_qs);
                        r_state <= S_MA;
                    end
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_acc   <= w_prod;
                    r_state <= S_DS;
                end
                S_DS: begin
                    r_ds    <= pidc_pkg::sat32((r_acc + w_prod) >>> 16);
                    r_state <= S_MD;
                end
                S_MD: r_state <= S_D;
                S_D: begin
                    r_d     <= pidc_pkg::sat32(w_prod >>> 16);
                    r_state <= S_MI;
                end
                S_MI: r_state <= S_IA;
                S_IA: begin
                    r_integ <= 56'(pidc_pkg::sat48(w_integ_sum));
                    r_state <= S_MH;
                end
                S_MH: r_state <= S_ML;
                S_ML: begin
                    r_acc   <= w_prod <<< 0;
                    r_state <= S_I;
                end
                S_I: begin
                    if (w_clamp_hi || w_clamp_lo) begin
                        r_i      <= w_clamp_hi ? w_lim : -w_lim;
                        r_iclamp <= 1'b1;
                        r_neg    <= w_clamp_hi ? (w_lim < 0) : (w_lim > 0);
                        r_state  <= (r_integ_gain != '0) ? S_LDIV : S_OC;
                    end else begin
                        r_i     <= w_i;
                        r_state <= S_OC;
                    end
                end
                S_LDIV: begin
                    if (w_ddone) begin
                        r_integ <= w_qs[55:0];
                        r_state <= S_OC;
                    end
                end
                S_OC: begin
                    if (w_sat_hi || w_sat_lo) begin
                        r_res   <= w_sat_hi ? r_drive_max : r_drive_min;
                        r_dsat  <= 1'b1;
                        r_neg   <= w_exc < 0;
                        r_state <= (r_integ_gain != '0) ? S_BDIV : S_FIN;
                    end else begin
                        r_res   <= w_out[31:0];
                        r_state <= S_FIN;
                    end
                end
                S_BDIV: begin
                    if (w_ddone) begin
                        r_integ <= 56'(pidc_pkg::sat48(w_bc));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ov || i_out_ready)) begin
            r_ores   <= r_res;
            r_osat   <= r_dsat;
            r_oclamp <= r_iclamp;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_result_value    = r_ores;
    assign o_drive_saturated = r_osat;
    assign o_integ_clamped   = r_oclamp;

    `PIDC_ASSERT_IMPL(a_sat_at_limit, o_out_valid && o_drive_saturated, (o_result_value == r_drive_max) || (o_result_value == r_drive_min))
    `PIDC_ASSERT_IMPL(a_div_in_wait, w_dbusy, (r_state == S_DDIV) || (r_state == S_LDIV) || (r_state == S_BDIV))
    `PIDC_ASSERT_NEXT(a_busy_after_acc, w_in_acc, !o_in_ready)

endmodule
